[hdl/qrs_pkg.sv]
// Package for the quadratic root solver: word types, root kind codes and
// datapath widths. No dependencies.
package qrs_pkg;

  typedef struct packed {
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         root_kind;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
  } out_word_t;

  localparam logic [1:0] KIND_ERROR    = 2'd0;
  localparam logic [1:0] KIND_COMPLEX  = 2'd1;
  localparam logic [1:0] KIND_EQUAL    = 2'd2;
  localparam logic [1:0] KIND_DISTINCT = 2'd3;

  // |d| < 2^33, radicand |d| * 2^16 < 2^49
  localparam int unsigned DISC_W      = 35;
  localparam int unsigned SQ_W        = 50;
  localparam int unsigned SQRT_STEPS  = 25;
  localparam int unsigned ROOT_W      = 25;
  // numerators: |nb +- s| < 2^26
  localparam int unsigned NUM_W       = 27;
  localparam int unsigned NMAG_W      = 26;
  // dividend |n| * 128 < 2^33, divisor |a| <= 2^15
  localparam int unsigned DIV_STEPS   = 33;
  localparam int unsigned REM_W       = 17;
  localparam int unsigned DIVSR_W     = 16;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] a;
    logic signed [15:0] b;
  } side_t;

endpackage

[hdl/quadratic_root_solver.sv]
// Quadratic root solver top level: discriminant, pipelined square root and
// two pipelined dividers by |a| (2a with the 2 folded into scaling). Uses qrs_pkg.
//
// Throughput: one word per cycle while the output is not stalled; the datapath
// is an input register, then one register stage per square-root bit (25) and
// per quotient bit (33), plus product, discriminant, numerator and saturation
// stages. A stalled output freezes the whole pipe.
// Reset: rst_ni clears every stage valid bit; payload registers are not reset.
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // Global advance: every stage moves unless the output word is held.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- stage A: input register
  logic     va_q;
  in_word_t wa_q;

  // ---------------- stage B: products b*b and 4ac, zero test
  logic               vb_q;
  logic signed [31:0] bb_q;
  logic signed [33:0] ac4_q;
  logic               zb_q;
  logic signed [15:0] ab_q, bq_q;

  // ---------------- stage C: discriminant and root kind
  logic                      vc_q;
  logic signed [DISC_W-1:0]  dc_q;
  side_t                     sc_q;

  logic [1:0] kind_c;
  logic signed [DISC_W-1:0] disc_c;
  always_comb begin
    disc_c = DISC_W'(bb_q) - DISC_W'(ac4_q);
    if (zb_q)                      kind_c = KIND_ERROR;
    else if (disc_c < 0)           kind_c = KIND_COMPLEX;
    else if (disc_c == '0)         kind_c = KIND_EQUAL;
    else                           kind_c = KIND_DISTINCT;
  end

  // ---------------- square root: one result bit per stage
  logic            sv_q [SQRT_STEPS];
  logic [SQ_W-1:0] sx_q [SQRT_STEPS];
  logic [SQ_W-1:0] sr_q [SQRT_STEPS];
  side_t           ss_q [SQRT_STEPS];
  logic [SQ_W-1:0] sx_d [SQRT_STEPS];
  logic [SQ_W-1:0] sr_d [SQRT_STEPS];

  logic [DISC_W-1:0] dmag;
  assign dmag = dc_q[DISC_W-1] ? DISC_W'(-dc_q) : DISC_W'(dc_q);

  always_comb begin
    logic [SQ_W-1:0] xi, ri, bitv, t;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        xi = SQ_W'(dmag) << 16;
        ri = '0;
      end else begin
        xi = sx_q[k-1];
        ri = sr_q[k-1];
      end
      bitv = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      t = ri + bitv;
      if (xi >= t) begin
        sx_d[k] = xi - t;
        sr_d[k] = (ri >> 1) + bitv;
      end else begin
        sx_d[k] = xi;
        sr_d[k] = ri >> 1;
      end
    end
  end

  // ---------------- stage N: numerators
  logic                    vn_q;
  logic signed [NUM_W-1:0] n1_q, n2_q;
  side_t                   sn_q;

  logic signed [NUM_W-1:0] nb_n, s_n;
  side_t                   sl_n;
  assign sl_n = ss_q[SQRT_STEPS-1];
  assign nb_n = -(NUM_W'(sl_n.b) <<< 8);
  assign s_n  = $signed(NUM_W'(sr_q[SQRT_STEPS-1][ROOT_W-1:0]));

  // ---------------- dividers: one quotient bit per stage, two lanes
  logic               dv_q  [DIV_STEPS];
  logic [1:0]         dk_q  [DIV_STEPS];
  logic [DIVSR_W-1:0] dam_q [DIV_STEPS];
  logic [REM_W-1:0]   dr_q  [2][DIV_STEPS];
  logic [DIV_STEPS-1:0] dq_q [2][DIV_STEPS];
  logic               dn_q  [2][DIV_STEPS];
  logic [REM_W-1:0]   dr_d  [2][DIV_STEPS];
  logic [DIV_STEPS-1:0] dq_d [2][DIV_STEPS];
  logic               dn_d  [2];

  logic [DIVSR_W-1:0] am_n;
  assign am_n = sn_q.a[15] ? DIVSR_W'(-sn_q.a) : DIVSR_W'(sn_q.a);

  always_comb begin
    logic signed [NUM_W-1:0] n;
    logic [NMAG_W-1:0]       nm;
    logic [REM_W-1:0]        ri, t;
    logic [DIV_STEPS-1:0]    qi;
    logic [DIVSR_W-1:0]      am;
    for (int l = 0; l < 2; l++) begin
      n  = (l == 0) ? n1_q : n2_q;
      nm = n[NUM_W-1] ? NMAG_W'(-n) : NMAG_W'(n);
      dn_d[l] = n[NUM_W-1] ^ sn_q.a[15];
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (k == 0) begin
          ri = '0;
          qi = {nm, 7'b0};
          am = am_n;
        end else begin
          ri = dr_q[l][k-1];
          qi = dq_q[l][k-1];
          am = dam_q[k-1];
        end
        t = {ri[REM_W-2:0], qi[DIV_STEPS-1]};
        if (t >= REM_W'(am)) begin
          dr_d[l][k] = t - REM_W'(am);
          dq_d[l][k] = {qi[DIV_STEPS-2:0], 1'b1};
        end else begin
          dr_d[l][k] = t;
          dq_d[l][k] = {qi[DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- output: sign and saturation
  function automatic logic signed [31:0] sat_q(input logic [DIV_STEPS-1:0] q,
                                               input logic neg);
    logic [DIV_STEPS-1:0] lim;
    logic [DIV_STEPS-1:0] m;
    begin
      lim = neg ? DIV_STEPS'(33'h0_8000_0000) : DIV_STEPS'(33'h0_7FFF_FFFF);
      m = (q > lim) ? lim : q;
      sat_q = neg ? -$signed(m[31:0]) : $signed(m[31:0]);
    end
  endfunction

  out_word_t out_d;
  always_comb begin
    out_d.root_kind = dk_q[DIV_STEPS-1];
    if (dk_q[DIV_STEPS-1] == KIND_ERROR) begin
      out_d.first_value  = '0;
      out_d.second_value = '0;
    end else begin
      out_d.first_value  = sat_q(dq_q[0][DIV_STEPS-1], dn_q[0][DIV_STEPS-1]);
      out_d.second_value = sat_q(dq_q[1][DIV_STEPS-1], dn_q[1][DIV_STEPS-1]);
    end
  end

  // ---------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vn_q <= 1'b0;
      out_valid_o <= 1'b0;
      for (int k = 0; k < SQRT_STEPS; k++) sv_q[k] <= 1'b0;
      for (int k = 0; k < DIV_STEPS; k++)  dv_q[k] <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      sv_q[0] <= vc_q;
      for (int k = 1; k < SQRT_STEPS; k++) sv_q[k] <= sv_q[k-1];
      vn_q <= sv_q[SQRT_STEPS-1];
      dv_q[0] <= vn_q;
      for (int k = 1; k < DIV_STEPS; k++) dv_q[k] <= dv_q[k-1];
      out_valid_o <= dv_q[DIV_STEPS-1];
    end
  end

  // ---------------- payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      wa_q  <= in_word_i;

      bb_q  <= wa_q.coef_b * wa_q.coef_b;
      ac4_q <= (34'(wa_q.coef_a) * 34'(wa_q.coef_c)) <<< 2;
      zb_q  <= (wa_q.coef_a == '0) || (wa_q.coef_b == '0) || (wa_q.coef_c == '0);
      ab_q  <= wa_q.coef_a;
      bq_q  <= wa_q.coef_b;

      dc_q      <= disc_c;
      sc_q.kind <= kind_c;
      sc_q.a    <= ab_q;
      sc_q.b    <= bq_q;

      for (int k = 0; k < SQRT_STEPS; k++) begin
        sx_q[k] <= sx_d[k];
        sr_q[k] <= sr_d[k];
        ss_q[k] <= (k == 0) ? sc_q : ss_q[k-1];
      end

      sn_q <= sl_n;
      if (sl_n.kind == KIND_COMPLEX) begin
        n1_q <= nb_n;
        n2_q <= s_n;
      end else begin
        n1_q <= nb_n + s_n;
        n2_q <= nb_n - s_n;
      end

      for (int k = 0; k < DIV_STEPS; k++) begin
        dk_q[k]  <= (k == 0) ? sn_q.kind : dk_q[k-1];
        dam_q[k] <= (k == 0) ? am_n : dam_q[k-1];
        for (int l = 0; l < 2; l++) begin
          dr_q[l][k] <= dr_d[l][k];
          dq_q[l][k] <= dq_d[l][k];
          dn_q[l][k] <= (k == 0) ? dn_d[l] : dn_q[l][k-1];
        end
      end

      out_word_o <= out_d;
    end
  end

endmodule
